[sv/kl_pkg.sv]
// Shared types and keyword tables for the keyword lexer.
package kl_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_WORD  = 2'd2,
        MODE_LABEL = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        KIND_IDENT   = 4'd0,
        KIND_LABEL   = 4'd1,
        KIND_INT     = 4'd2,
        KIND_INPUT   = 4'd3,
        KIND_OUTPUT  = 4'd4,
        KIND_GOTO    = 4'd5,
        KIND_IF      = 4'd6,
        KIND_THEN    = 4'd7,
        KIND_EQUAL   = 4'd8,
        KIND_PLUS    = 4'd9,
        KIND_LESS    = 4'd10,
        KIND_INVALID = 4'd11,
        KIND_END     = 4'd12
    } t_kind;

    localparam int KW_COUNT   = 5;
    localparam int KW_MAXLEN  = 6;
    localparam int KW_IDX_W   = $clog2(KW_MAXLEN);

    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
        '{"i", "n", "p", "u", "t", 8'h00},
        '{"o", "u", "t", "p", "u", "t"},
        '{"g", "o", "t", "o", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "h", "e", "n", 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd6, 3'd4, 3'd2, 3'd4};

    localparam t_kind KW_KIND [KW_COUNT] = '{KIND_INPUT, KIND_OUTPUT, KIND_GOTO, KIND_IF,
                                             KIND_THEN};

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

endpackage

[sv/keyword_lexer.sv]
// Keyword lexer: byte-serial scanner with a small token output queue.
// A token is written into the output queue on the clock edge that accepts the byte that completes it.
// Throughput: one byte per cycle while o_stall is low; a byte that both ends a pending token and emits its own
// yields two tokens, which drain one per cycle while i_stall is low through a four-token output queue.
// Input stalls while fewer than two queue slots are free.
// Reset (i_rst_n low, synchronous): scanner idle, position zero, queue empty.
module keyword_lexer #(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_BITS   = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_char_byte,
    output logic                     o_valid,
    input  logic                     i_stall,
    output kl_pkg::t_kind            o_token_kind,
    output logic [POSITION_BITS-1:0] o_token_start,
    output logic [LENGTH_BITS-1:0]   o_token_length,
    output logic                     o_length_clipped,
    output logic                     o_last_of_run
);
    import kl_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    typedef struct packed {
        t_kind                     kind;
        logic [POSITION_BITS-1:0]  start;
        logic [LENGTH_BITS-1:0]    len;
        logic                      clip;
        logic                      last;
    } t_token;

    t_mode                    r_mode,  n_mode;
    logic [POSITION_BITS-1:0] r_pos,   n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [LENGTH_BITS-1:0]   r_len,   n_len;
    logic                     r_clip,  n_clip;
    logic [KW_COUNT-1:0]      r_mask,  n_mask;

    t_token                   r_q [QDEPTH];
    logic [QPTR_W-1:0]        r_wr, r_rd;
    logic [QCNT_W-1:0]        r_cnt;

    logic      in_fire, out_fire;
    logic      is_digit, is_alpha, is_space, is_wordc, cont;
    logic      flush_v, fix_v, push_a, push_b;
    t_token    flush_tok, fix_tok, tok_a, tok_b;
    t_kind     word_kind;
    logic [KW_COUNT-1:0] fits;
    logic [KW_COUNT-1:0] fits_first;
    logic [KW_IDX_W-1:0] idx;

    assign in_fire  = i_valid && !o_stall;
    assign out_fire = o_valid && !i_stall;

    assign is_digit = (i_char_byte >= "0") && (i_char_byte <= "9");
    assign is_alpha = ((i_char_byte >= "a") && (i_char_byte <= "z")) ||
                      ((i_char_byte >= "A") && (i_char_byte <= "Z"));
    assign is_space = (i_char_byte == 8'd32) ||
                      ((i_char_byte >= 8'd9) && (i_char_byte <= 8'd13));
    assign is_wordc = is_alpha || is_digit || (i_char_byte == "_");
    assign cont     = ((r_mode == MODE_NUM) && is_digit) ||
                      (((r_mode == MODE_WORD) || (r_mode == MODE_LABEL)) && is_wordc);

    assign idx = r_len[KW_IDX_W-1:0];

    // Keyword k still fits if the run so far is shorter and the byte matches its next letter.
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            fits[k] = (r_len < {{(LENGTH_BITS-3){1'b0}}, KW_LEN[k]}) &&
                      (KW_TEXT[k][idx] == i_char_byte);
            fits_first[k] = (KW_TEXT[k][0] == i_char_byte);
        end
    end

    // Lowest-numbered surviving keyword of exact length wins.
    always_comb begin
        word_kind = KIND_IDENT;
        if (!r_clip) begin
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
                if (r_mask[k] && (r_len == {{(LENGTH_BITS-3){1'b0}}, KW_LEN[k]})) begin
                    word_kind = KW_KIND[k];
                end
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_clip  = r_clip;
        n_mask  = r_mask;
        flush_v = 1'b0;
        fix_v   = 1'b0;

        flush_tok.start = r_start;
        flush_tok.len   = r_len;
        flush_tok.clip  = r_clip;
        flush_tok.last  = 1'b0;
        case (r_mode)
            MODE_NUM:   flush_tok.kind = KIND_INT;
            MODE_LABEL: flush_tok.kind = KIND_LABEL;
            MODE_WORD:  flush_tok.kind = word_kind;
            default:    flush_tok.kind = KIND_IDENT;
        endcase

        fix_tok.kind  = KIND_INVALID;
        fix_tok.start = r_pos;
        fix_tok.len   = '0;
        fix_tok.clip  = 1'b0;
        fix_tok.last  = 1'b1;

        if (in_fire) begin
            n_pos = r_pos + 1'b1;
            if (cont) begin
                if (r_mode == MODE_WORD) begin
                    n_mask = r_mask & fits;
                end
                if (r_len == LEN_MAX) begin
                    n_clip = 1'b1;
                end else begin
                    n_len = r_len + 1'b1;
                end
            end else begin
                if (r_mode != MODE_IDLE) begin
                    flush_v = 1'b1;
                    n_mode  = MODE_IDLE;
                    n_start = '0;
                    n_len   = '0;
                    n_clip  = 1'b0;
                    n_mask  = KW_ALL;
                end
                if (i_char_byte == 8'h00) begin
                    fix_v        = 1'b1;
                    fix_tok.kind = KIND_END;
                    // End of text: everything restarts, next byte is offset zero.
                    n_pos   = '0;
                    n_mode  = MODE_IDLE;
                    n_start = '0;
                    n_len   = '0;
                    n_clip  = 1'b0;
                    n_mask  = KW_ALL;
                end else if (is_space) begin
                    fix_v = 1'b0;
                end else if (i_char_byte == "=") begin
                    fix_v        = 1'b1;
                    fix_tok.kind = KIND_EQUAL;
                end else if (i_char_byte == "+") begin
                    fix_v        = 1'b1;
                    fix_tok.kind = KIND_PLUS;
                end else if (i_char_byte == "<") begin
                    fix_v        = 1'b1;
                    fix_tok.kind = KIND_LESS;
                end else if (i_char_byte == ":") begin
                    n_mode  = MODE_LABEL;
                    n_start = r_pos + 1'b1;
                    n_len   = '0;
                    n_clip  = 1'b0;
                    n_mask  = KW_ALL;
                end else if (is_digit) begin
                    n_mode  = MODE_NUM;
                    n_start = r_pos;
                    n_len   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                    n_clip  = 1'b0;
                    n_mask  = KW_ALL;
                end else if (is_alpha || (i_char_byte == "_")) begin
                    n_mode  = MODE_WORD;
                    n_start = r_pos;
                    n_len   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                    n_clip  = 1'b0;
                    n_mask  = fits_first;
                end else begin
                    fix_v        = 1'b1;
                    fix_tok.kind = KIND_INVALID;
                end
            end
        end
    end

    // Order the beats: flushed token first, then the byte's own token.
    always_comb begin
        if (flush_v) begin
            tok_a      = flush_tok;
            tok_a.last = !fix_v;
            tok_b      = fix_tok;
            push_a     = 1'b1;
            push_b     = fix_v;
        end else begin
            tok_a      = fix_tok;
            tok_b      = fix_tok;
            push_a     = fix_v;
            push_b     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_clip  <= 1'b0;
            r_mask  <= KW_ALL;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_clip  <= n_clip;
            r_mask  <= n_mask;
            r_wr    <= r_wr + QPTR_W'(push_a) + QPTR_W'(push_b);
            if (out_fire) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt   <= r_cnt + QCNT_W'(push_a) + QCNT_W'(push_b) - QCNT_W'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_a) begin
            r_q[r_wr] <= tok_a;
        end
        if (push_b) begin
            r_q[r_wr + QPTR_W'(push_a)] <= tok_b;
        end
    end

    // Hold off input unless two slots are free.
    assign o_stall          = (r_cnt > QCNT_W'(QDEPTH - 2));
    assign o_valid          = (r_cnt != '0);
    assign o_token_kind     = r_q[r_rd].kind;
    assign o_token_start    = r_q[r_rd].start;
    assign o_token_length   = r_q[r_rd].len;
    assign o_length_clipped = r_q[r_rd].clip;
    assign o_last_of_run    = r_q[r_rd].last;

endmodule

[test/keyword_lexer_tb.sv]
// Self-checking testbench for the keyword lexer: random and directed text against a token predictor.
`timescale 1ns / 1ps

module keyword_lexer_tb;
    import kl_pkg::*;

    localparam int POS_W = 16;
    localparam int LEN_W = 8;
    localparam logic [LEN_W-1:0] LEN_SAT = '1;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             clip;
        logic             last_run;
    } t_token;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic [7:0]       i_char_byte = 8'h00;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    t_kind            o_token_kind;
    logic [POS_W-1:0] o_token_start;
    logic [LEN_W-1:0] o_token_length;
    logic             o_length_clipped;
    logic             o_last_of_run;

    keyword_lexer #(
        .POSITION_BITS(POS_W),
        .LENGTH_BITS  (LEN_W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_byte     (i_char_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_token_kind    (o_token_kind),
        .o_token_start   (o_token_start),
        .o_token_length  (o_token_length),
        .o_length_clipped(o_length_clipped),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // text bytes waiting for the driver, and tokens the scanner still owes
    logic [7:0] text_q[$];
    t_token     token_expect_q[$];

    int  text_total = 0;
    int  beats_in = 0;
    int  tokens_checked = 0;
    int  err_count = 0;
    int  cycle_cnt = 0;
    bit  in_beat = 1'b0;

    string kw_words[KW_COUNT] = '{"input", "output", "goto", "if", "then"};

    // predictor state
    t_mode            scan_mode = MODE_IDLE;
    logic [POS_W-1:0] scan_pos = '0;
    logic [POS_W-1:0] pend_start = '0;
    logic [LEN_W-1:0] pend_len = '0;
    logic             pend_clip = 1'b0;
    logic [KW_COUNT-1:0] kw_mask = KW_ALL;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SP || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic t_token make_token(input t_kind kind, input logic [POS_W-1:0] start,
                                          input logic [LEN_W-1:0] len, input logic clip);
        t_token t;
        t.kind = kind;
        t.start = start;
        t.len = len;
        t.clip = clip;
        t.last_run = 1'b0;
        return t;
    endfunction

    function automatic void open_token(input t_mode mode, input logic [POS_W-1:0] start);
        scan_mode = mode;
        pend_start = start;
        pend_len = '0;
        pend_clip = 1'b0;
        kw_mask = KW_ALL;
    endfunction

    function automatic void grow_token(input logic [7:0] c);
        int idx;
        idx = pend_len;
        if (scan_mode == MODE_WORD) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (idx < KW_LEN[k]) begin
                    if (KW_TEXT[k][idx] != c) kw_mask[k] = 1'b0;
                end else begin
                    kw_mask[k] = 1'b0;
                end
            end
        end
        if (pend_len == LEN_SAT) pend_clip = 1'b1;
        else pend_len = pend_len + 1'b1;
    endfunction

    function automatic t_kind pending_kind();
        t_kind kind;
        kind = KIND_IDENT;
        if (scan_mode == MODE_NUM) begin
            kind = KIND_INT;
        end else if (scan_mode == MODE_LABEL) begin
            kind = KIND_LABEL;
        end else if (!pend_clip) begin
            // first surviving keyword of matching length wins
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
                if (kw_mask[k] && pend_len == LEN_W'(KW_LEN[k])) kind = KW_KIND[k];
            end
        end
        return kind;
    endfunction

    // advance the predictor by one text byte and queue the tokens it completes
    function automatic void scan_byte(input logic [7:0] c);
        t_token           done_tok;
        t_token           own_tok;
        bit               have_done;
        bit               have_own;
        logic [POS_W-1:0] pos;
        have_done = 1'b0;
        have_own = 1'b0;
        pos = scan_pos;
        scan_pos = scan_pos + 1'b1;
        if ((scan_mode == MODE_NUM && is_digit(c)) ||
            ((scan_mode == MODE_WORD || scan_mode == MODE_LABEL) && is_word(c))) begin
            grow_token(c);
        end else begin
            if (scan_mode != MODE_IDLE) begin
                done_tok = make_token(pending_kind(), pend_start, pend_len, pend_clip);
                have_done = 1'b1;
                open_token(MODE_IDLE, '0);
            end
            if (c == CH_NUL) begin
                own_tok = make_token(KIND_END, pos, '0, 1'b0);
                have_own = 1'b1;
                open_token(MODE_IDLE, '0);
                scan_pos = '0;
            end else if (is_space(c)) begin
            end else if (c == "=") begin
                own_tok = make_token(KIND_EQUAL, pos, '0, 1'b0);
                have_own = 1'b1;
            end else if (c == "+") begin
                own_tok = make_token(KIND_PLUS, pos, '0, 1'b0);
                have_own = 1'b1;
            end else if (c == "<") begin
                own_tok = make_token(KIND_LESS, pos, '0, 1'b0);
                have_own = 1'b1;
            end else if (c == ":") begin
                open_token(MODE_LABEL, pos + 1'b1);
            end else if (is_digit(c)) begin
                open_token(MODE_NUM, pos);
                grow_token(c);
            end else if (is_alpha(c) || c == "_") begin
                open_token(MODE_WORD, pos);
                grow_token(c);
            end else begin
                own_tok = make_token(KIND_INVALID, pos, '0, 1'b0);
                have_own = 1'b1;
            end
            if (have_own) own_tok.last_run = 1'b1;
            else if (have_done) done_tok.last_run = 1'b1;
            if (have_done) token_expect_q.push_back(done_tok);
            if (have_own) token_expect_q.push_back(own_tok);
        end
    endfunction

    task automatic push_byte(input logic [7:0] c);
        text_q.push_back(c);
        text_total++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_run(input logic [7:0] c, input int n);
        for (int i = 0; i < n; i++) push_byte(c);
    endtask

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(63);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return "_";
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(6);
        return (r == 6) ? CH_SP : 8'(9 + r);
    endfunction

    function automatic logic [7:0] rand_invalid();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (is_word(c) || is_space(c) || c == "=" || c == "+" || c == "<" || c == ":");
        return c;
    endfunction

    // one random lexeme, mostly well formed, then an optional whitespace run
    task automatic gen_token(input bit allow_end);
        int         r;
        int         n;
        string      s;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 20) begin
            push_text(kw_words[$urandom_range(KW_COUNT - 1)]);
        end else if (r < 30) begin
            s = kw_words[$urandom_range(KW_COUNT - 1)];
            case ($urandom_range(2))
                0: push_text(s.substr(0, $urandom_range(s.len() - 2)));
                1: begin
                    push_text(s);
                    push_byte(rand_word_char());
                end
                default: begin
                    s[0] = s[0] - 8'h20;
                    push_text(s);
                end
            endcase
        end else if (r < 50) begin
            n = $urandom_range(9);
            push_byte(($urandom_range(7) == 0) ? 8'("_") : 8'("a" + $urandom_range(25)));
            for (int i = 0; i < n; i++) push_byte(rand_word_char());
        end else if (r < 62) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(9)));
        end else if (r < 72) begin
            n = $urandom_range(6);
            push_byte(":");
            for (int i = 0; i < n; i++) push_byte(rand_word_char());
        end else if (r < 84) begin
            case ($urandom_range(2))
                0: push_byte("=");
                1: push_byte("+");
                default: push_byte("<");
            endcase
        end else if (r < 90) begin
            push_byte(rand_invalid());
        end else if (r < 96) begin
            c = 8'($urandom_range(255));
            if (!allow_end && c == CH_NUL) c = 8'h01;
            push_byte(c);
        end else begin
            push_byte(allow_end ? CH_NUL : CH_SP);
        end
        if ($urandom_range(9) < 6) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) push_byte(rand_space());
        end
    endtask

    function automatic bit idle_now();
        // no idling at the start of each cycle_cnt period, random idling elsewhere
        if ((cycle_cnt % 4000) < 700) return 1'b0;
        return $urandom_range(99) < 8;
    endfunction

    // driver: present a new byte at the falling edge once the previous beat went through
    always @(negedge i_clk) begin
        cycle_cnt++;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            i_stall <= idle_now();
            if (!i_valid || in_beat) begin
                if (text_q.size() > 0 && !idle_now()) begin
                    i_valid <= 1'b1;
                    i_char_byte <= text_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [POS_W-1:0] exp_v,
                               input logic [POS_W-1:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t: token %0d %s mismatch: expected %0d, got %0d",
                     $time, tokens_checked, name, exp_v, act_v);
        end
    endtask

    // monitor: predict on input beats, compare output beats against the oldest token
    always @(posedge i_clk) begin
        t_token exp_tok;
        in_beat = i_rst_n && i_valid && !o_stall;
        if (in_beat) begin
            beats_in++;
            scan_byte(i_char_byte);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (token_expect_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected token: expected none, got kind %0d start %0d",
                         $time, o_token_kind, o_token_start);
            end else begin
                exp_tok = token_expect_q.pop_front();
                check_field("kind", POS_W'(exp_tok.kind), POS_W'(o_token_kind));
                check_field("start", exp_tok.start, o_token_start);
                check_field("length", POS_W'(exp_tok.len), POS_W'(o_token_length));
                check_field("clipped", POS_W'(exp_tok.clip), POS_W'(o_length_clipped));
                check_field("last_of_run", POS_W'(exp_tok.last_run), POS_W'(o_last_of_run));
            end
            tokens_checked++;
        end
    end

    initial begin
        // directed: keywords, near misses, every fixed token, whitespace, unknown bytes
        push_text("input output goto if then inputs outpu iff Then go_to ");
        push_text("x_1 _ :lbl : 42=+<#");
        push_byte(8'h80);
        push_byte(8'hFF);
        push_byte(8'h7F);
        push_byte(8'h01);
        for (int c = 9; c <= 13; c++) push_byte(8'(c));
        push_text("a:b if: 12ab then=7");
        push_byte(CH_NUL);
        push_byte(CH_NUL);
        // literals at and past the length limit
        push_run("a", 255);
        push_byte(CH_SP);
        push_text("input");
        push_run("z", 260);
        push_byte(CH_SP);
        push_run("9", 300);
        push_byte("<");
        push_byte(":");
        push_run("_", 260);
        push_byte(CH_NUL);

        // random text
        while (text_total < 1650) gen_token(1'b1);
        push_byte(CH_NUL);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_in < text_total) @(posedge i_clk);
        while (token_expect_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Scanned %0d text bytes and checked %0d tokens,", text_total, tokens_checked);
        $display("covering keywords, labels, clipped literals, unknown bytes and end-of-text flushes.");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d tokens still outstanding", token_expect_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
